// ----- rtl/fbc_pkg.sv -----
// fbc_pkg: shared types and constants for the frustum box cull test
// no dependencies; used by fbc_back, the top unit and the bench
package fbc_pkg;

  // six frustum planes, each one configuration register
  localparam int PLANE_COUNT = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  // plane coefficient fields: a,b,c in Q1.14, d integer
  localparam int COEF_W  = 16;
  localparam int Q_SHIFT = 14;

  // one plane register, d in the top bits down to a in the low bits
  typedef struct packed {
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] a;
  } plane_t;

endpackage

// ----- rtl/fbc_in_if.sv -----
// fbc_in_if / fbc_out_if: valid/ready channels for voxel beats and cull results
// depends on nothing; width follows COORD_WIDTH
interface fbc_in_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] voxel_x;
  logic signed [COORD_WIDTH-1:0] voxel_y;
  logic signed [COORD_WIDTH-1:0] voxel_z;

  modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                  input ready);
  modport sink (input valid, input voxel_x, input voxel_y, input voxel_z,
                output ready);
endinterface

interface fbc_out_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, output inside_res, input ready);
  modport sink (input valid, input inside_res, output ready);
endinterface

// ----- rtl/fbc_front.sv -----
// fbc_front: accepts voxel beats and forms the low and high box corners per axis
// depends on fbc_in_if; feeds fbc_queue
module fbc_front #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  fbc_in_if.sink                       in_ch,
  output logic                         q_valid,
  input  logic                         q_ready,
  output logic [6*(COORD_WIDTH+1)-1:0] q_data
);

  localparam int CW = COORD_WIDTH + 1;

  logic          valid_r;
  logic [6*CW-1:0] corners_r;
  logic [6*CW-1:0] corners_nxt;
  logic signed [CW-1:0] cx, cy, cz;

  // widen by one bit so centre +- 1 stays exact
  always_comb begin
    cx = CW'(in_ch.voxel_x);
    cy = CW'(in_ch.voxel_y);
    cz = CW'(in_ch.voxel_z);
    corners_nxt = {cz + CW'(1), cz - CW'(1),
                   cy + CW'(1), cy - CW'(1),
                   cx + CW'(1), cx - CW'(1)};
  end

  assign in_ch.ready = !valid_r || q_ready;
  assign q_valid     = valid_r;
  assign q_data      = corners_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      corners_r <= corners_nxt;
    end
  end

endmodule

// ----- rtl/fbc_queue.sv -----
// fbc_queue: two-entry fifo between the corner front end and the plane test back end
// depends on nothing
module fbc_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/fbc_back.sv -----
// fbc_back: positive-vertex plane tests, three register stages, result beat out
// depends on fbc_pkg and fbc_out_if; fed by fbc_queue
module fbc_back #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  fbc_pkg::plane_t [fbc_pkg::PLANE_COUNT-1:0]  planes,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [6*(COORD_WIDTH+1)-1:0]                in_data,
  fbc_out_if.source                                   out_ch
);

  localparam int CW  = COORD_WIDTH + 1;
  localparam int PW  = fbc_pkg::COEF_W + CW;
  localparam int DW  = fbc_pkg::COEF_W + fbc_pkg::Q_SHIFT;
  localparam int SW  = ((PW > DW) ? PW : DW) + 3;
  localparam int NP  = fbc_pkg::PLANE_COUNT;

  logic                 en;
  logic                 va_r, vb_r, out_valid_r;
  logic                 inside_r;
  logic signed [PW-1:0] prod_r [NP][3];
  logic signed [PW-1:0] prod_nxt [NP][3];
  logic [NP-1:0]        keep_r;
  logic [NP-1:0]        keep_nxt;
  logic signed [CW-1:0] lo_c [3];
  logic signed [CW-1:0] hi_c [3];
  logic signed [SW-1:0] sum [NP];

  // whole pipe advances unless a finished result is stalled
  assign en       = !out_valid_r || out_ch.ready;
  assign in_ready = en;

  // unpack corners
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_c[k] = in_data[(2*k)*CW +: CW];
      hi_c[k] = in_data[(2*k+1)*CW +: CW];
    end
  end

  // stage a: pick positive vertex per axis by normal sign and multiply
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      prod_nxt[p][0] = planes[p].a * (planes[p].a[fbc_pkg::COEF_W-1] ? lo_c[0] : hi_c[0]);
      prod_nxt[p][1] = planes[p].b * (planes[p].b[fbc_pkg::COEF_W-1] ? lo_c[1] : hi_c[1]);
      prod_nxt[p][2] = planes[p].c * (planes[p].c[fbc_pkg::COEF_W-1] ? lo_c[2] : hi_c[2]);
    end
  end

  // stage b: add products and scaled offset, keep the plane if not negative
  always_comb begin
    for (int p = 0; p < NP; p++) begin
      sum[p] = SW'(prod_r[p][0]) + SW'(prod_r[p][1]) + SW'(prod_r[p][2])
             + (SW'(planes[p].d) <<< fbc_pkg::Q_SHIFT);
      keep_nxt[p] = !sum[p][SW-1];
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= in_valid;
      vb_r        <= va_r;
      out_valid_r <= vb_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= prod_nxt;
      keep_r   <= keep_nxt;
      inside_r <= &keep_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.inside_res = inside_r;

  // a product stage that moves always lands in the sum stage
  a_stage_a_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && en) |=> vb_r)
    else $error("stage a beat lost");

  // a sum stage that moves always becomes a result beat
  a_stage_b_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && en) |=> out_valid_r)
    else $error("stage b beat lost");

  // a stall freezes the per-plane keep bits
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en) |=> $stable(keep_r))
    else $error("keep bits changed during stall");

endmodule

// ----- rtl/frustum_box_cull_test_unit.sv -----
// frustum_box_cull_test_unit: tests the box around a voxel centre against six planes
// a beat passes the front corner register, the two-entry queue, then the product, keep and inside registers
// throughput: one voxel per cycle unless stalled; six planes tested in parallel, two multiply/add stages
// a stalled result holds the pipe; the two-entry queue keeps the front accepting until it fills
// reset (synchronous, rst_n low) empties the pipe and clears all plane registers to zero
// depends on fbc_pkg, fbc_in_if, fbc_out_if, fbc_front, fbc_queue, fbc_back
module frustum_box_cull_test_unit #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fbc_in_if.sink                         in_ch,
  fbc_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int QW = 6 * (COORD_WIDTH + 1);

  fbc_pkg::plane_t [fbc_pkg::PLANE_COUNT-1:0] planes_r;

  logic          f_valid, f_ready;
  logic [QW-1:0] f_data;
  logic          b_valid, b_ready;
  logic [QW-1:0] b_data;

  // plane registers; writes beyond the last plane are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      planes_r <= '0;
    end else if (cfg_we && (int'(cfg_index) < fbc_pkg::PLANE_COUNT)) begin
      planes_r[cfg_index] <= fbc_pkg::plane_t'(cfg_data);
    end
  end

  fbc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_data  (f_data)
  );

  fbc_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  fbc_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .planes   (planes_r),
    .in_valid (b_valid),
    .in_ready (b_ready),
    .in_data  (b_data),
    .out_ch   (out_ch)
  );

endmodule

// ----- bench/fbc_cull_checker.sv -----
// fbc_cull_checker: watches the voxel, result and plane register ports of the cull unit
// keeps its own plane registers, predicts inside_res for every voxel beat, compares in order
// depends on fbc_pkg, fbc_in_if, fbc_out_if
module fbc_cull_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fbc_in_if                              in_mon,
  fbc_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             result_backlog
);

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    bit                            kept;
  } cull_verdict_t;

  // shadow copy of the six plane registers
  fbc_pkg::plane_t planes [fbc_pkg::PLANE_COUNT];
  cull_verdict_t   verdict_q [$];

  initial begin
    fail_count     = 0;
    result_backlog = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // one axis of the positive vertex: low corner for a negative normal, else high corner
  function automatic longint corner_term(input logic signed [fbc_pkg::COEF_W-1:0] coef,
                                         input logic signed [COORD_WIDTH-1:0] centre);
    longint k;
    longint v;
    k = coef;
    v = centre;
    return (k < 0) ? k * (v - 1) : k * (v + 1);
  endfunction

  // box survives when no plane has its positive vertex behind it
  function automatic bit box_survives(input logic signed [COORD_WIDTH-1:0] x,
                                      input logic signed [COORD_WIDTH-1:0] y,
                                      input logic signed [COORD_WIDTH-1:0] z);
    longint margin;
    bit     kept;
    kept = 1'b1;
    for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++) begin
      margin = corner_term(planes[i].a, x) + corner_term(planes[i].b, y)
             + corner_term(planes[i].c, z)
             + longint'(planes[i].d) * (longint'(1) <<< fbc_pkg::Q_SHIFT);
      if (margin < 0) kept = 1'b0;
    end
    return kept;
  endfunction

  always @(posedge clk) begin
    cull_verdict_t head;
    if (!rst_n) begin
      for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++) planes[i] = '0;
      verdict_q.delete();
    end else begin
      // plane register writes; indexes past the last plane are dropped
      if (cfg_we && cfg_index < fbc_pkg::PLANE_COUNT) planes[cfg_index] = cfg_data;

      // result beat against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("result beat inside_res %0b with none pending",
                                    out_mon.inside_res));
        end else begin
          head = verdict_q.pop_front();
          if (out_mon.inside_res !== head.kept)
            report_mismatch($sformatf("voxel (%0d,%0d,%0d) inside_res %0b, predicted %0b",
                                      head.x, head.y, head.z, out_mon.inside_res, head.kept));
        end
      end

      // voxel beat: predict its verdict with the current planes
      if (in_mon.valid && in_mon.ready) begin
        head.x    = in_mon.voxel_x;
        head.y    = in_mon.voxel_y;
        head.z    = in_mon.voxel_z;
        head.kept = box_survives(in_mon.voxel_x, in_mon.voxel_y, in_mon.voxel_z);
        verdict_q.push_back(head);
      end
    end
    result_backlog = verdict_q.size();
  end

endmodule

// ----- bench/tb_frustum_box_cull_test_unit.sv -----
// tb_frustum_box_cull_test_unit: drives voxel beats and plane settings into the cull unit
// directed corners first, then random phases under several frustums; fbc_cull_checker judges
// depends on fbc_pkg, fbc_in_if, fbc_out_if, frustum_box_cull_test_unit, fbc_cull_checker
module tb_frustum_box_cull_test_unit;

  localparam int COORD_WIDTH  = 16;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_BEATS  = 240;
  localparam int Q_ONE        = 1 << fbc_pkg::Q_SHIFT;

  typedef enum logic [fbc_pkg::CFG_IDX_W-1:0] {
    REG_LEFT, REG_RIGHT, REG_BOTTOM, REG_TOP, REG_NEAR, REG_FAR, REG_SPARE_6, REG_SPARE_7
  } plane_reg_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [fbc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fbc_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                             gaps_on;
  int                             idle_cycles;
  int                             fail_count;
  int                             result_backlog;
  fbc_pkg::plane_t                plane_set [fbc_pkg::PLANE_COUNT];

  fbc_in_if #(.COORD_WIDTH(COORD_WIDTH)) in_ch ();
  fbc_out_if                             out_ch ();

  frustum_box_cull_test_unit #(.COORD_WIDTH(COORD_WIDTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fbc_cull_checker #(.COORD_WIDTH(COORD_WIDTH)) cull_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .result_backlog (result_backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= gaps_on ? ($urandom_range(0, 99) >= 29) : 1'b1;
  end

  // watchdog on cycles without any beat or register write
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("frustum_box_cull_test_unit verification failed");
          $finish;
        end
      end
    end
  end

  // one voxel beat, with random idle cycles ahead of it while gaps_on is set
  task automatic send_voxel(input int x, input int y, input int z);
    while (gaps_on && $urandom_range(0, 99) < 29) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.voxel_x <= COORD_WIDTH'(x);
    in_ch.voxel_y <= COORD_WIDTH'(y);
    in_ch.voxel_z <= COORD_WIDTH'(z);
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // stop sending and let every pending result come out
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (result_backlog != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // load all six planes, then one write to an unused index
  task automatic write_planes();
    for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= plane_reg_t'(i);
      cfg_data  <= plane_set[i];
      @(negedge clk);
    end
    cfg_index <= $urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7;
    cfg_data  <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic fbc_pkg::plane_t axis_plane(input int a, input int b, input int c,
                                                 input int d);
    fbc_pkg::plane_t p;
    p.a = fbc_pkg::COEF_W'(a);
    p.b = fbc_pkg::COEF_W'(b);
    p.c = fbc_pkg::COEF_W'(c);
    p.d = fbc_pkg::COEF_W'(d);
    return p;
  endfunction

  // span 0 means anywhere in the coordinate range
  function automatic int rand_coord(input int span);
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      case ($urandom_range(0, 3))
        0:       return -32768;
        1:       return 32767;
        2:       return -32767;
        default: return 32766;
      endcase
    end
    if (r < 4 || span == 0) return int'($urandom);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int rand_coef();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      4:       return 1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  // axis-aligned plane; lower keeps the side toward larger coordinates
  function automatic fbc_pkg::plane_t slab_plane(input int axis, input bit lower,
                                                 input int bound);
    int mag;
    int n;
    mag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32767) : Q_ONE;
    n   = lower ? mag : -mag;
    case (axis)
      0:       return axis_plane(n, 0, 0, bound);
      1:       return axis_plane(0, n, 0, bound);
      default: return axis_plane(0, 0, n, bound);
    endcase
  endfunction

  // plane set for one random phase and the coordinate spread that suits it
  task automatic build_set(input int kind, output int span);
    case (kind)
      0, 1: begin
        for (int ax = 0; ax < 3; ax++) begin
          plane_set[2 * ax]     = slab_plane(ax, 1'b1, $urandom_range(1, 200));
          plane_set[2 * ax + 1] = slab_plane(ax, 1'b0, $urandom_range(1, 200));
        end
        span = 250;
      end
      2: begin
        for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++)
          plane_set[i] = $urandom_range(0, 1) ? fbc_pkg::plane_t'({$urandom, $urandom}) : '0;
        span = 0;
      end
      3: begin
        for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++)
          plane_set[i] = axis_plane(rand_coef(), rand_coef(), rand_coef(), rand_coef());
        span = 0;
      end
      4: begin
        for (int i = 0; i < fbc_pkg::PLANE_COUNT; i++)
          plane_set[i] = axis_plane(int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom_range(0, 32768)) - 16384,
                                    int'($urandom_range(0, 32768)) - 16384,
                                    $urandom_range(0, 2000));
        span = 3000;
      end
      default: begin
        for (int ax = 0; ax < 3; ax++) begin
          plane_set[2 * ax]     = slab_plane(ax, 1'b1, int'($urandom_range(0, 65535)) - 32768);
          plane_set[2 * ax + 1] = slab_plane(ax, 1'b0, int'($urandom_range(0, 65535)) - 32768);
        end
        span = 0;
      end
    endcase
  endtask

  initial begin
    int span;
    rst_n         = 1'b0;
    gaps_on       = 1'b1;
    idle_cycles   = 0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.voxel_x = '0;
    in_ch.voxel_y = '0;
    in_ch.voxel_z = '0;
    out_ch.ready  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // planes all zero after reset: nothing is culled, even at the coordinate extremes
    send_voxel(-32768, -32768, -32768);
    send_voxel(32767, 32767, 32767);
    send_voxel(0, 0, 0);
    send_voxel(-1, 1, -1);
    wait_idle();

    // unit cube frustum of half size 100, zero normal components on the other axes
    plane_set[REG_LEFT]   = axis_plane(Q_ONE, 0, 0, 100);
    plane_set[REG_RIGHT]  = axis_plane(-Q_ONE, 0, 0, 100);
    plane_set[REG_BOTTOM] = axis_plane(0, Q_ONE, 0, 100);
    plane_set[REG_TOP]    = axis_plane(0, -Q_ONE, 0, 100);
    plane_set[REG_NEAR]   = axis_plane(0, 0, Q_ONE, 100);
    plane_set[REG_FAR]    = axis_plane(0, 0, -Q_ONE, 100);
    write_planes();
    send_voxel(0, 0, 0);
    send_voxel(-101, 0, 0);   // vertex exactly on the plane
    send_voxel(-102, 0, 0);
    send_voxel(101, 0, 0);
    send_voxel(102, 0, 0);
    send_voxel(0, -102, 0);
    send_voxel(0, 0, 102);
    send_voxel(0, 101, -101);
    wait_idle();

    // extreme coefficients, all-ones register, vertices past the coordinate range
    plane_set[REG_LEFT]   = axis_plane(-32768, -32768, -32768, -32768);
    plane_set[REG_RIGHT]  = axis_plane(32767, 32767, 32767, 32767);
    plane_set[REG_BOTTOM] = axis_plane(-1, 0, 1, 0);
    plane_set[REG_TOP]    = axis_plane(-1, -1, -1, -1);
    plane_set[REG_NEAR]   = '0;
    plane_set[REG_FAR]    = '0;
    write_planes();
    send_voxel(-32768, -32768, -32768);
    send_voxel(32767, 32767, 32767);
    send_voxel(0, 0, 0);
    send_voxel(-1, 0, 1);
    send_voxel(1, 0, -1);
    send_voxel(32767, -32768, 0);
    wait_idle();

    // random phases; phase 1 runs without any idling
    for (int k = 0; k < RAND_PHASES; k++) begin
      build_set(k, span);
      write_planes();
      gaps_on = (k != 1);
      for (int n = 0; n < PHASE_BEATS; n++)
        send_voxel(rand_coord(span), rand_coord(span), rand_coord(span));
      wait_idle();
      gaps_on = 1'b1;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && result_backlog == 0) begin
      $display("frustum_box_cull_test_unit verification clean");
    end else begin
      $display("frustum_box_cull_test_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fbc_pkg.sv
rtl/fbc_in_if.sv
rtl/fbc_front.sv
rtl/fbc_queue.sv
rtl/fbc_back.sv
rtl/frustum_box_cull_test_unit.sv
bench/fbc_cull_checker.sv
bench/tb_frustum_box_cull_test_unit.sv
